/* rtl/stc_pkg.sv */
// Shared widths, constants and gain table helpers for the speed to timer compare block.
package stc_pkg;

  localparam int unsigned SPEED_W       = 16;
  localparam int unsigned COUNT_W       = 16;
  localparam int unsigned TICK_W        = 20;
  localparam int unsigned GAIN_FRAC_DEF = 14;
  localparam int unsigned TICK_RESET    = 15625;

  localparam int unsigned KMH_W    = 26;
  localparam int unsigned KMH_FRAC = 16;
  localparam int unsigned MUL_W    = 29;
  localparam int unsigned RECIP_W  = 29;
  localparam int unsigned DIV5_SH  = 31;
  localparam logic [RECIP_W-1:0] RECIP5 = 29'd429496730;

  localparam int unsigned QUO_W = 18;

  localparam int unsigned THR_N  = 13;
  localparam int unsigned GAIN_N = 14;
  localparam int unsigned SEL_W  = 4;

  localparam int unsigned THR_KMH [THR_N] = '{
    180, 100, 80, 60, 50, 40, 35, 30, 25, 20, 15, 10, 5
  };

  localparam int unsigned GAIN_HUND [GAIN_N] = '{
    71, 72, 77, 79, 81, 85, 88, 89, 90, 92, 95, 110, 120, 200
  };

  function automatic longint unsigned gain_q(input int unsigned hund,
                                             input int unsigned frac);
    longint unsigned scaled;
    scaled = longint'(hund) << frac;
    return (scaled + 64'd50) / 64'd100;
  endfunction

endpackage

/* rtl/stc_if.sv */
// Request channel interfaces for speed samples, compare results and the tick rate register.
interface stc_in_if import stc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_mps;

  modport source (output valid, output speed_mps, input ready);
  modport sink (input valid, input speed_mps, output ready);
endinterface

interface stc_out_if import stc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] compare_value;
  logic               saturated;

  modport source (output valid, output compare_value, output saturated, input ready);
  modport sink (input valid, input compare_value, input saturated, output ready);
endinterface

interface stc_cfg_if import stc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] timer_tick_rate;

  modport source (output valid, output timer_tick_rate, input ready);
  modport sink (input valid, input timer_tick_rate, output ready);
endinterface

/* rtl/stc_front.sv */
// Front stages: speed to km/h conversion, gain selection and adjusted speed product.
module stc_front import stc_pkg::*; #(
  parameter int unsigned GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [SPEED_W-1:0]                    speed,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [KMH_W+GAIN_FRAC_BITS+2-1:0]     adj
);

  localparam int unsigned GAIN_W = GAIN_FRAC_BITS + 2;
  localparam int unsigned ADJ_W  = KMH_W + GAIN_W;
  localparam int unsigned PROD_W = MUL_W + RECIP_W;

  logic [GAIN_W-1:0]  gain_tab [GAIN_N];
  logic [MUL_W-1:0]   speed_x;
  logic [PROD_W-1:0]  prod;
  logic [KMH_W-1:0]   kmh;
  logic [KMH_W-1:0]   kmh_next;
  logic               kmh_valid;
  logic               kmh_ready;
  logic [SEL_W-1:0]   sel;
  logic [GAIN_W-1:0]  gain;
  logic [ADJ_W-1:0]   adj_next;
  logic               adj_valid;
  logic               adj_ready;

  genvar g;
  for (g = 0; g < GAIN_N; g++) begin : g_gain
    localparam logic [GAIN_W-1:0] VAL = GAIN_W'(gain_q(GAIN_HUND[g], GAIN_FRAC_BITS));
    assign gain_tab[g] = VAL;
  end

  assign adj_ready = !adj_valid || out_ready;
  assign kmh_ready = !kmh_valid || adj_ready;
  assign in_ready  = kmh_ready;
  assign out_valid = adj_valid;

  // speed * 4608, then divide by 5 through the reciprocal
  assign speed_x  = (MUL_W'(speed) << 12) + (MUL_W'(speed) << 9);
  assign prod     = PROD_W'(speed_x) * PROD_W'(RECIP5);
  assign kmh_next = prod[DIV5_SH +: KMH_W];

  always_comb begin
    sel = SEL_W'(THR_N);
    for (int k = THR_N - 1; k >= 0; k--) begin
      if (kmh > (KMH_W'(THR_KMH[k]) << KMH_FRAC)) begin
        sel = SEL_W'(k);
      end
    end
  end

  assign gain     = gain_tab[sel];
  assign adj_next = ADJ_W'(kmh) * ADJ_W'(gain);

  always_ff @(posedge clk) begin
    if (rst) begin
      kmh_valid <= 1'b0;
      adj_valid <= 1'b0;
    end else begin
      if (kmh_ready) begin
        kmh_valid <= in_valid;
      end
      if (adj_ready) begin
        adj_valid <= kmh_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && kmh_ready) begin
      kmh <= kmh_next;
    end
    if (kmh_valid && adj_ready) begin
      adj <= adj_next;
    end
  end

endmodule

/* rtl/stc_div_cell.sv */
// One restoring division cell: produces one quotient bit and passes the remainder on.
module stc_div_cell import stc_pkg::*; #(
  parameter int unsigned ADJ_W = KMH_W + GAIN_FRAC_DEF + 2,
  parameter int unsigned REM_W = ADJ_W + QUO_W,
  parameter int unsigned SHIFT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [REM_W-1:0] in_rem,
  input  logic [ADJ_W-1:0] in_adj,
  input  logic [QUO_W-1:0] in_q,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [REM_W-1:0] out_rem,
  output logic [ADJ_W-1:0] out_adj,
  output logic [QUO_W-1:0] out_q
);

  logic [REM_W-1:0] cmp;
  logic             ge;
  logic [REM_W-1:0] rem_next;
  logic [QUO_W-1:0] q_next;
  logic             valid;

  assign cmp      = REM_W'(in_adj) << SHIFT;
  assign ge       = in_rem >= cmp;
  assign rem_next = ge ? in_rem - cmp : in_rem;
  assign q_next   = {in_q[QUO_W-2:0], ge};

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_rem <= rem_next;
      out_adj <= in_adj;
      out_q   <= q_next;
    end
  end

endmodule

/* rtl/speed_to_timer_compare_top.sv */
// Top level: speed sample to speedometer timer compare value.
//
//  channel  modport  payload                         moves
//  sample   sink     speed_mps[15:0]                 speed request in
//  result   source   compare_value[15:0], saturated  compare request out
//  cfg      sink     timer_tick_rate[19:0]           tick rate register write
//
// One request per cycle sustained while results are taken; registers: two front stages
// (km/h product, gained product), 18 division cells, one output register.
// Reset clears all stage valid bits and loads the tick rate with 15625.
// A stalled result holds in the output register; ready ripples back and
// empty stages keep filling, so bubbles close up behind a stall.
module speed_to_timer_compare_top import stc_pkg::*; #(
  parameter int unsigned GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
  input  logic  clk,
  input  logic  rst,
  stc_in_if.sink     sample,
  stc_out_if.source  result,
  stc_cfg_if.sink    cfg
);

  localparam int unsigned ADJ_W = KMH_W + GAIN_FRAC_BITS + 2;
  localparam int unsigned REM_W = ADJ_W + QUO_W;
  localparam int unsigned NUM_SH = KMH_FRAC + GAIN_FRAC_BITS;

  logic [TICK_W-1:0]  tick_rate;
  logic               f_valid;
  logic               f_ready;
  logic [ADJ_W-1:0]   f_adj;

  logic               c_valid [QUO_W+1];
  logic               c_ready [QUO_W+1];
  logic [REM_W-1:0]   c_rem   [QUO_W+1];
  logic [ADJ_W-1:0]   c_adj   [QUO_W+1];
  logic [QUO_W-1:0]   c_q     [QUO_W+1];

  logic [QUO_W-1:0]   q_fin;
  logic [COUNT_W-1:0] cnt_next;
  logic               sat_next;
  logic               res_valid;
  logic [COUNT_W-1:0] res_cnt;
  logic               res_sat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= TICK_W'(TICK_RESET);
    end else if (cfg.valid && cfg.ready) begin
      tick_rate <= cfg.timer_tick_rate;
    end
  end

  stc_front #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .speed     (sample.speed_mps),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .adj       (f_adj)
  );

  assign c_valid[0] = f_valid;
  assign f_ready    = c_ready[0];
  assign c_rem[0]   = REM_W'(tick_rate) << NUM_SH;
  assign c_adj[0]   = f_adj;
  assign c_q[0]     = '0;

  genvar i;
  for (i = 0; i < QUO_W; i++) begin : g_cell
    stc_div_cell #(
      .ADJ_W (ADJ_W),
      .REM_W (REM_W),
      .SHIFT (QUO_W - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .in_rem    (c_rem[i]),
      .in_adj    (c_adj[i]),
      .in_q      (c_q[i]),
      .out_valid (c_valid[i+1]),
      .out_ready (c_ready[i+1]),
      .out_rem   (c_rem[i+1]),
      .out_adj   (c_adj[i+1]),
      .out_q     (c_q[i+1])
    );
  end

  assign q_fin = c_q[QUO_W];

  // top quotient bit covers overflow and a zero divisor
  always_comb begin
    if (q_fin[QUO_W-1]) begin
      cnt_next = '1;
      sat_next = 1'b1;
    end else if (q_fin[QUO_W-2:0] == '0) begin
      cnt_next = '0;
      sat_next = 1'b1;
    end else if (q_fin[COUNT_W] && (q_fin[COUNT_W-1:0] != '0)) begin
      cnt_next = '1;
      sat_next = 1'b1;
    end else begin
      cnt_next = COUNT_W'(q_fin - QUO_W'(1));
      sat_next = 1'b0;
    end
  end

  assign c_ready[QUO_W] = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (c_ready[QUO_W]) begin
      res_valid <= c_valid[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (c_valid[QUO_W] && c_ready[QUO_W]) begin
      res_cnt <= cnt_next;
      res_sat <= sat_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.compare_value = res_cnt;
  assign result.saturated     = res_sat;

endmodule

/* rtl/stc_check.sv */
// Port-level assertions for the speed to timer compare top level.
module stc_check import stc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] compare_value,
  input logic               saturated,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(compare_value) && $stable(saturated))
    else $error("stalled result changed");

  a_flow_open: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked while output drains");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write refused");

endmodule

bind speed_to_timer_compare_top stc_check u_check (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (sample.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .compare_value (result.compare_value),
  .saturated     (result.saturated),
  .cfg_valid     (cfg.valid),
  .cfg_ready     (cfg.ready)
);

/* bench/tb_speed_to_timer_compare_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for the speed to timer compare block: random and edge speeds, checked results.
module tb_speed_to_timer_compare_top;
  import stc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_TICKS = 30;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam int unsigned KMH_KNEE [13] = '{
    180, 100, 80, 60, 50, 40, 35, 30, 25, 20, 15, 10, 5
  };
  localparam int unsigned GAIN_PCT [14] = '{
    71, 72, 77, 79, 81, 85, 88, 89, 90, 92, 95, 110, 120, 200
  };

  typedef struct packed {
    logic [SPEED_W-1:0] speed_mps;
    logic [COUNT_W-1:0] compare_value;
    logic               saturated;
  } compare_req_t;

  logic clk = 1'b0;
  logic rst;

  stc_in_if  sample ();
  stc_out_if result ();
  stc_cfg_if cfg ();

  speed_to_timer_compare_top dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .result (result),
    .cfg    (cfg)
  );

  logic [SPEED_W-1:0] speed_backlog [$];
  compare_req_t       compare_due [$];
  logic [TICK_W-1:0]  tick_rate_now = TICK_W'(TICK_RESET);
  logic               speed_taken = 1'b0;
  int unsigned        src_idle = 0;
  int unsigned        snk_idle = 0;
  int unsigned        mismatches = 0;
  int unsigned        checked = 0;
  int unsigned        saturated_seen = 0;
  int unsigned        tick_writes = 0;
  int unsigned        cycles = 0;

  always #5 clk = ~clk;

  function automatic compare_req_t predict_compare(input logic [SPEED_W-1:0] spd,
                                                   input logic [TICK_W-1:0] tick);
    longint unsigned kmh, gain, adj, q;
    int unsigned     sel;
    compare_req_t    r;
    kmh = (64'(spd) * 64'd9216) / 64'd10;
    sel = 13;
    for (int k = 12; k >= 0; k--) begin
      if (kmh > (64'(KMH_KNEE[k]) << KMH_FRAC)) begin
        sel = k;
      end
    end
    gain = ((64'(GAIN_PCT[sel]) << GAIN_FRAC_DEF) + 64'd50) / 64'd100;
    adj = kmh * gain;
    r.speed_mps = spd;
    r.saturated = 1'b1;
    if (adj == 0) begin
      r.compare_value = '1;
    end else begin
      q = (64'(tick) << (KMH_FRAC + GAIN_FRAC_DEF)) / adj;
      if (q == 0) begin
        r.compare_value = '0;
      end else if (q - 1 > 64'hFFFF) begin
        r.compare_value = '1;
      end else begin
        r.compare_value = COUNT_W'(q - 1);
        r.saturated = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
  endtask

  // Check results, record accepted requests and register writes.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, compare_due.size());
      $display("tb: failure");
      $finish;
    end
    if (!rst && result.valid && result.ready) begin
      compare_req_t want;
      if (compare_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result compare_value=%0d saturated=%0b",
                                result.compare_value, result.saturated));
      end else begin
        want = compare_due.pop_front();
        checked++;
        if (result.saturated === 1'b1) begin
          saturated_seen++;
        end
        if (result.compare_value !== want.compare_value ||
            result.saturated !== want.saturated) begin
          note_mismatch($sformatf(
            "speed 0x%04h: compare_value exp %0d got %0d, saturated exp %0b got %0b",
            want.speed_mps, want.compare_value, result.compare_value,
            want.saturated, result.saturated));
        end
      end
    end
    if (!rst && sample.valid && sample.ready) begin
      compare_due.push_back(predict_compare(sample.speed_mps, tick_rate_now));
    end
    speed_taken <= !rst && sample.valid && sample.ready;
    if (!rst && cfg.valid && cfg.ready) begin
      tick_rate_now = cfg.timer_tick_rate;
      tick_writes++;
    end
  end

  // Feed speed requests from the backlog.
  always @(negedge clk) begin
    if (rst) begin
      sample.valid <= 1'b0;
    end else if (!sample.valid || speed_taken) begin
      if (speed_backlog.size() > 0 && $urandom_range(99) >= src_idle) begin
        sample.valid     <= 1'b1;
        sample.speed_mps <= speed_backlog.pop_front();
      end else begin
        sample.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    result.ready <= ($urandom_range(99) >= snk_idle);
  end

  task automatic settle();
    while (speed_backlog.size() != 0 || sample.valid || compare_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic load_tick_rate(input logic [TICK_W-1:0] rate);
    int unsigned seen;
    @(negedge clk);
    seen = tick_writes;
    cfg.valid           <= 1'b1;
    cfg.timer_tick_rate <= rate;
    do begin
      @(negedge clk);
    end while (tick_writes == seen);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    logic [TICK_W-1:0]  tick_plan [6];
    logic [SPEED_W-1:0] spd;
    int unsigned        knee;
    rst                 = 1'b1;
    sample.valid        = 1'b0;
    sample.speed_mps    = '0;
    result.ready        = 1'b0;
    cfg.valid           = 1'b0;
    cfg.timer_tick_rate = '0;
    tick_plan[0] = 20'd1;
    tick_plan[1] = 20'hFFFFF;
    tick_plan[2] = 20'd0;
    tick_plan[3] = 20'd1000000;
    tick_plan[4] = 20'd15625;
    tick_plan[5] = TICK_W'($urandom_range(1, 1000000));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle = 16;
    snk_idle = 85;
    // zero speed, count overflow, top of range, then both sides of every gain knee
    speed_backlog.push_back(16'h0000);
    speed_backlog.push_back(16'h0001);
    speed_backlog.push_back(16'hFFFF);
    for (int k = 0; k < 13; k++) begin
      spd = SPEED_W'((KMH_KNEE[k] * 655360) / 9216);
      speed_backlog.push_back(spd);
      speed_backlog.push_back(SPEED_W'(spd + 1));
    end
    settle();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        src_idle = 85;
        snk_idle = 16;
      end else if (p == 4) begin
        src_idle = 0;
        snk_idle = 0;
      end
      load_tick_rate(tick_plan[p]);
      for (int chunk = 0; chunk < 2; chunk++) begin
        repeat (125) begin
          case ($urandom_range(3))
            0: spd = SPEED_W'($urandom());
            1: spd = SPEED_W'($urandom_range(0, 13000));
            2: begin
              knee = $urandom_range(12);
              spd = SPEED_W'((KMH_KNEE[knee] * 655360) / 9216 + $urandom_range(4) - 2);
            end
            default: spd = SPEED_W'($urandom_range(0, 400));
          endcase
          speed_backlog.push_back(spd);
        end
        // hold the sender until every result is back
        settle();
      end
    end

    if (compare_due.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", compare_due.size()));
    end
    $display("summary: %0d speed requests checked, %0d of them saturated", checked,
             saturated_seen);
    $display("summary: %0d tick rate writes incl. 0, 1, 1000000 and 0xFFFFF; %0d mismatches",
             tick_writes, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/stc_pkg.sv
rtl/stc_if.sv
rtl/stc_front.sv
rtl/stc_div_cell.sv
rtl/speed_to_timer_compare_top.sv
rtl/stc_check.sv
bench/tb_speed_to_timer_compare_top.sv
